[src/mpc_pkg.sv]
package mpc_pkg;

   // number format and coordinate widths
   localparam int FRAC_BITS    = 27;
   localparam int COORD_BITS   = 12;
   localparam int DVD_BITS     = COORD_BITS + FRAC_BITS;
   localparam int REM_BITS     = 12;
   // coordinate times remainder, and the reciprocal that divides it
   localparam int PROD_BITS    = 2 * COORD_BITS;
   localparam int RCP_BITS     = PROD_BITS + 2;
   localparam int DIV_CYCLES   = 2;
   localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

   // color keys
   localparam logic [3:0] KEY_LOW   = 4'd3;
   localparam logic [3:0] KEY_LIMIT = 4'd10;

   // configuration register indexes
   localparam logic [1:0] CSR_ZOOM_SCALE = 2'd0;
   localparam logic [1:0] CSR_PAN_REAL   = 2'd1;
   localparam logic [1:0] CSR_PAN_IMAG   = 2'd2;
   localparam logic [1:0] CSR_MAX_ITER   = 2'd3;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_data_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] palette_key;
      logic [7:0] iter_count;
   } rsp_data_type;

   typedef struct packed {
      logic [30:0]        zoom_scale;
      logic signed [31:0] pan_real;
      logic signed [31:0] pan_imag;
      logic [7:0]         iter_limit;
   } cfg_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DIV  = 8'b0000_0010,
      ST_UOFF = 8'b0000_0100,
      ST_MMUL = 8'b0000_1000,
      ST_MAPC = 8'b0001_0000,
      ST_ZMUL = 8'b0010_0000,
      ST_ZUPD = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic u_calc;
      logic map_mul;
      logic map_fin;
      logic z_mul;
      logic z_upd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic below_limit;
      logic escape;
   } stat_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return 32'(v);
      end
   endfunction

   // 8-bit value mod 7 by folding octal digits
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [4:0] s;
      s = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
      if (s >= 5'd14) begin
         s = s - 5'd14;
      end else if (s >= 5'd7) begin
         s = s - 5'd7;
      end
      return s[2:0];
   endfunction

   function automatic logic [3:0] pick_key(input logic [7:0] count, input logic [7:0] limit);
      if (count < 8'd4) begin
         return KEY_LOW;
      end else if (count == limit) begin
         return KEY_LIMIT;
      end else begin
         return {1'b0, mod7(count)};
      end
   endfunction

   // fixed palette, unknown keys are black
   function automatic logic [23:0] palette(input logic [3:0] key);
      case (key)
         4'd0:    return {8'd255, 8'd128, 8'd0};
         4'd1:    return {8'd255, 8'd0,   8'd0};
         4'd2:    return {8'd255, 8'd0,   8'd255};
         4'd3:    return {8'd0,   8'd0,   8'd255};
         4'd4:    return {8'd0,   8'd255, 8'd255};
         4'd5:    return {8'd0,   8'd255, 8'd0};
         4'd6:    return {8'd255, 8'd255, 8'd0};
         default: return 24'd0;
      endcase
   endfunction

endpackage

[src/mpc_ctrl.sv]
module mpc_ctrl
   import mpc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type                state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]  div_cnt_ff, div_cnt_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
               state_in = ST_UOFF;
            end
         end
         ST_UOFF: begin
            cmd.u_calc = 1'b1;
            state_in   = ST_MMUL;
         end
         ST_MMUL: begin
            cmd.map_mul = 1'b1;
            state_in    = ST_MAPC;
         end
         ST_MAPC: begin
            cmd.map_fin = 1'b1;
            state_in    = ST_ZMUL;
         end
         ST_ZMUL: begin
            if (stat.below_limit) begin
               cmd.z_mul = 1'b1;
               state_in  = ST_ZUPD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ZUPD: begin
            if (stat.escape) begin
               state_in = ST_FIN;
            end else begin
               cmd.z_upd = 1'b1;
               state_in  = ST_ZMUL;
            end
         end
         ST_FIN: begin
            cmd.out_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[src/mpc_datapath.sv]
module mpc_datapath
   import mpc_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 400,
   parameter int IMAGE_HEIGHT = 400
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_data_type req_data,
   input  cfg_type      cfg,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   // coord * 2^27 / size = coord * whole + (coord * rem) / size,
   // the last division done by an exact reciprocal for operands below 2^24
   localparam int MUL_BITS = PROD_BITS + RCP_BITS;
   localparam int SHIFT_X  = PROD_BITS + $clog2(IMAGE_WIDTH);
   localparam int SHIFT_Y  = PROD_BITS + $clog2(IMAGE_HEIGHT);
   localparam logic [FRAC_BITS-1:0] QUO_X =
      FRAC_BITS'((64'd1 << FRAC_BITS) / 64'(IMAGE_WIDTH));
   localparam logic [FRAC_BITS-1:0] QUO_Y =
      FRAC_BITS'((64'd1 << FRAC_BITS) / 64'(IMAGE_HEIGHT));
   localparam logic [REM_BITS-1:0] REM_X =
      REM_BITS'((64'd1 << FRAC_BITS) % 64'(IMAGE_WIDTH));
   localparam logic [REM_BITS-1:0] REM_Y =
      REM_BITS'((64'd1 << FRAC_BITS) % 64'(IMAGE_HEIGHT));
   localparam logic [RCP_BITS-1:0] RCP_X =
      RCP_BITS'(((64'd1 << SHIFT_X) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
   localparam logic [RCP_BITS-1:0] RCP_Y =
      RCP_BITS'(((64'd1 << SHIFT_Y) + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));

   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [PROD_BITS-1:0]  tx_ff, ty_ff;
   logic [DVD_BITS-1:0]   ax_ff, ay_ff;
   logic [DVD_BITS-1:0]   qx_ff, qy_ff;
   logic signed [31:0]    ux_ff, uy_ff;
   logic signed [31:0]    cr_ff, ci_ff;
   logic signed [31:0]    zr_ff, zi_ff;
   logic signed [63:0]    p0_ff, p1_ff, p2_ff;
   logic [7:0]            count_ff;
   logic                  rsp_valid_ff;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   logic [MUL_BITS-1:0]   fx, fy;
   logic signed [31:0]    op_a0, op_b0, op_a1, op_b1, op_a2, op_b2;
   logic signed [31:0]    zoom_s;
   logic signed [63:0]    ux_full, uy_full;
   logic signed [63:0]    sq_diff;
   logic [63:0]           mag;
   logic signed [31:0]    zr_in, zi_in, cr_in, ci_in;
   logic [3:0]            key;
   logic [23:0]           rgb;

   // capture the pixel word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_data.pixel_x;
         py_ff <= req_data.pixel_y;
      end
   end

   // coordinate division in two stages
   assign fx = MUL_BITS'(tx_ff) * MUL_BITS'(RCP_X);
   assign fy = MUL_BITS'(ty_ff) * MUL_BITS'(RCP_Y);

   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         tx_ff <= PROD_BITS'(px_ff) * PROD_BITS'(REM_X);
         ty_ff <= PROD_BITS'(py_ff) * PROD_BITS'(REM_Y);
         ax_ff <= DVD_BITS'(px_ff) * DVD_BITS'(QUO_X);
         ay_ff <= DVD_BITS'(py_ff) * DVD_BITS'(QUO_Y);
         qx_ff <= ax_ff + DVD_BITS'(fx >> SHIFT_X);
         qy_ff <= ay_ff + DVD_BITS'(fy >> SHIFT_Y);
      end
   end

   // recenter the quotient by one half
   assign ux_full = $signed(64'(qx_ff)) - 64'sd67108864;
   assign uy_full = $signed(64'(qy_ff)) - 64'sd67108864;

   always_ff @(posedge clock) begin
      if (cmd.u_calc) begin
         ux_ff <= sat32(ux_full);
         uy_ff <= sat32(uy_full);
      end
   end

   // two shared multipliers scale, then square; a third forms zr*zi
   assign zoom_s = $signed({1'b0, cfg.zoom_scale});

   always_comb begin
      if (cmd.map_mul) begin
         op_a0 = ux_ff;
         op_b0 = zoom_s;
         op_a1 = uy_ff;
         op_b1 = zoom_s;
      end else begin
         op_a0 = zr_ff;
         op_b0 = zr_ff;
         op_a1 = zi_ff;
         op_b1 = zi_ff;
      end
      op_a2 = zr_ff;
      op_b2 = zi_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.map_mul || cmd.z_mul) begin
         p0_ff <= 64'(op_a0) * 64'(op_b0);
         p1_ff <= 64'(op_a1) * 64'(op_b1);
         p2_ff <= 64'(op_a2) * 64'(op_b2);
      end
   end

   // point c from the scaled offsets
   assign cr_in = sat32(64'(sat32(p0_ff >>> FRAC_BITS)) + 64'(cfg.pan_real));
   assign ci_in = sat32(64'(sat32(p1_ff >>> FRAC_BITS)) + 64'(cfg.pan_imag));

   // escape test and next z
   assign mag     = 64'(p0_ff) + 64'(p1_ff);
   assign sq_diff = p0_ff - p1_ff;
   assign zr_in   = sat32(64'(sat32(sq_diff >>> FRAC_BITS)) + 64'(cr_ff));
   assign zi_in   = sat32(64'(sat32(p2_ff >>> (FRAC_BITS - 1))) + 64'(ci_ff));

   assign stat.escape      = |mag[63:2*FRAC_BITS+2];
   assign stat.below_limit = (count_ff < cfg.iter_limit);

   always_ff @(posedge clock) begin
      if (cmd.map_fin) begin
         cr_ff    <= cr_in;
         ci_ff    <= ci_in;
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
      end else if (cmd.z_upd) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= count_ff + 8'd1;
      end
   end

   // color key and palette lookup
   assign key = pick_key(count_ff, cfg.iter_limit);
   assign rgb = palette(key);

   always_comb begin
      rsp_data_in.red         = rgb[23:16];
      rsp_data_in.green       = rgb[15:8];
      rsp_data_in.blue        = rgb[7:0];
      rsp_data_in.palette_key = key;
      rsp_data_in.iter_count  = count_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.out_load;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/mandelbrot_pixel_colorizer.sv]
// Mandelbrot escape-time colorizer: a pixel word is taken when start is high and busy is
// low; exactly one result word follows on rsp_data, flagged by rsp_valid for a single
// cycle, and must be captured then since there is no way to stall it. After acceptance
// the coordinates are divided by the image size through a constant reciprocal, then
// come the recentering, zoom multiply and pan add, then each z update (square, then
// update, at most the iteration limit of them) through the shared 32x32 multipliers,
// then either a limit check or a last square and escape test, and a final palette
// step.
// busy drops in the cycle the result is shown, so the next pixel can start there.
// Configuration writes are taken at any time but belong to idle periods.
module mandelbrot_pixel_colorizer
   import mpc_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 400,
   parameter int IMAGE_HEIGHT = 400
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_valid,
   output rsp_data_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ZOOM_SCALE: cfg_in.zoom_scale = csr_wdata[30:0];
            CSR_PAN_REAL:   cfg_in.pan_real   = $signed(csr_wdata);
            CSR_PAN_IMAG:   cfg_in.pan_imag   = $signed(csr_wdata);
            CSR_MAX_ITER:   cfg_in.iter_limit = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zoom_scale <= 31'd536870912;
         cfg_ff.pan_real   <= -32'sd53687091;
         cfg_ff.pan_imag   <= 32'sd0;
         cfg_ff.iter_limit <= 8'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   mpc_datapath #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // result word only appears once the controller is back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // never two result words back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // an accepted word always starts work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start work");

   // low counts always map to the low key, and every count stays within the limit
   a_rsp_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.iter_count < 8'd4) |-> rsp_data.palette_key == KEY_LOW)
      else $error("low count gave wrong color key");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.iter_count <= cfg_ff.iter_limit)
      else $error("iteration count above limit");
`endif

endmodule
